@@ rtl/core/expression_token_lexer_defines.svh @@
// Assertion macros shared by the expression token lexer RTL.
`ifndef EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`define EXPRESSION_TOKEN_LEXER_DEFINES_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge outside reset.
`define ETL_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Condition that must hold in the cycle after the trigger.
`define ETL_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);
`else
`define ETL_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ETL_ASSERT_NEXT(label, clk, rst, trig, cond, msg)
`endif
`endif

@@ rtl/core/etl_pkg.sv @@
// Types, token codes and character constants of the expression token lexer.
`default_nettype none
package etl_pkg;

  // One input item: a character or an end of line.
  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  // One result item: a token.
  typedef struct packed {
    logic [3:0]  token_type;
    logic [63:0] token_text;
    logic [3:0]  token_length;
    logic        text_truncated;
    logic [7:0]  token_index;
    logic        last_result;
  } out_item_t;

  // Kind of the pending run.
  typedef enum logic [2:0] {
    RUN_NONE   = 3'b001,
    RUN_NUMBER = 3'b010,
    RUN_WORD   = 3'b100
  } run_kind_t;

  // Token type codes.
  localparam logic [3:0] TOK_LPAREN   = 4'd0;
  localparam logic [3:0] TOK_RPAREN   = 4'd1;
  localparam logic [3:0] TOK_PLUS     = 4'd2;
  localparam logic [3:0] TOK_MOD      = 4'd3;
  localparam logic [3:0] TOK_MINUS    = 4'd4;
  localparam logic [3:0] TOK_MUL      = 4'd5;
  localparam logic [3:0] TOK_DIV      = 4'd6;
  localparam logic [3:0] TOK_AND      = 4'd7;
  localparam logic [3:0] TOK_OR       = 4'd8;
  localparam logic [3:0] TOK_COMMA    = 4'd9;
  localparam logic [3:0] TOK_NUMBER   = 4'd10;
  localparam logic [3:0] TOK_FN2      = 4'd11;
  localparam logic [3:0] TOK_FN1      = 4'd12;
  localparam logic [3:0] TOK_VARIABLE = 4'd13;
  localparam logic [3:0] TOK_INVALID  = 4'd14;
  localparam logic [3:0] TOK_END      = 4'd15;

  // Character codes.
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MOD    = 8'h25;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_MUL    = 8'h2A;
  localparam logic [7:0] CH_DIV    = 8'h2F;
  localparam logic [7:0] CH_AND    = 8'h26;
  localparam logic [7:0] CH_OR     = 8'h7C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  // Keyword texts, first character in the low byte.
  localparam logic [63:0] KW_XOR = 64'h0000_0000_0072_6F78;
  localparam logic [63:0] KW_NOT = 64'h0000_0000_0074_6F6E;
  localparam logic [63:0] KW_LS  = 64'h0000_0000_0000_736C;
  localparam logic [63:0] KW_LR  = 64'h0000_0000_0000_726C;
  localparam logic [63:0] KW_RS  = 64'h0000_0000_0000_7372;
  localparam logic [63:0] KW_RR  = 64'h0000_0000_0000_7272;

  // Depth of the result queue and its index width.
  localparam int QUEUE_DEPTH = 3;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Result of a single-character lookup.
  typedef struct packed {
    logic       hit;
    logic [3:0] token_type;
  } single_t;

  function automatic single_t single_lookup(input logic [7:0] c);
    single_t s;
    s.hit = 1'b1;
    case (c)
      CH_LPAREN: s.token_type = TOK_LPAREN;
      CH_RPAREN: s.token_type = TOK_RPAREN;
      CH_PLUS:   s.token_type = TOK_PLUS;
      CH_MOD:    s.token_type = TOK_MOD;
      CH_MINUS:  s.token_type = TOK_MINUS;
      CH_MUL:    s.token_type = TOK_MUL;
      CH_DIV:    s.token_type = TOK_DIV;
      CH_AND:    s.token_type = TOK_AND;
      CH_OR:     s.token_type = TOK_OR;
      CH_COMMA:  s.token_type = TOK_COMMA;
      default: begin
        s.hit        = 1'b0;
        s.token_type = TOK_INVALID;
      end
    endcase
    return s;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Classifies a finished word run.
  function automatic logic [3:0] word_type(input logic [63:0] text,
                                           input logic [3:0] len,
                                           input logic ovf);
    logic [3:0] t;
    t = TOK_VARIABLE;
    if (!ovf && len == 4'd3 && text == KW_XOR) t = TOK_FN2;
    if (!ovf && len == 4'd3 && text == KW_NOT) t = TOK_FN1;
    if (!ovf && len == 4'd2 &&
        (text == KW_LS || text == KW_LR || text == KW_RS || text == KW_RR)) begin
      t = TOK_FN2;
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/expression_token_lexer.sv @@
// Expression token lexer: turns a character stream into expression tokens.
//
// The lexer takes one character or end-of-line item per clock and returns zero, one
// or two tokens for it. All decoding of an item is done in the cycle it is accepted,
// and its tokens are written into a three-entry result queue that feeds the output
// port. A steady stream producing at most one token per item runs at one item per
// cycle while the output is not stalled; an item that closes a run and also yields
// its own token (or an end of line with a run pending) writes two tokens, and the
// input stalls while two or more tokens are waiting in the queue. Token text keeps
// the first MAX_TOKEN_CHARS characters of a run and flags longer runs as truncated.
`default_nettype none
`include "expression_token_lexer_defines.svh"
module expression_token_lexer #(
  parameter int MAX_TOKEN_CHARS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              chr_valid,
  output logic                   chr_stall,
  input  wire etl_pkg::in_item_t chr_data,
  output logic                   tok_valid,
  input  wire logic              tok_stall,
  output etl_pkg::out_item_t     tok_data
);
  import etl_pkg::*;

  localparam logic [3:0] MAX_LEN = 4'(MAX_TOKEN_CHARS);

  // Lexer state.
  run_kind_t   run_kind, run_kind_next;
  logic [63:0] run_text, run_text_next;
  logic [3:0]  run_length, run_length_next;
  logic        run_overflow, run_overflow_next;
  logic [7:0]  token_counter, token_counter_next;

  // Result queue.
  out_item_t             q [QUEUE_DEPTH];
  out_item_t             q_next [QUEUE_DEPTH];
  logic [QUEUE_CW-1:0]   cnt, cnt_next;

  logic       accept;
  logic       pop;
  logic [7:0] c;
  logic       dig, let_c;
  single_t    sgl;
  logic       cont;
  logic       flush;
  logic [7:0] idx_after_flush;
  logic [7:0] idx_inc;
  logic       has_own;
  out_item_t  run_tok, own_tok, r0, r1;
  logic [1:0] n_res;
  logic [QUEUE_CW-1:0] base;

  assign accept    = chr_valid && !chr_stall;
  assign chr_stall = (cnt >= QUEUE_CW'(2));
  assign tok_valid = (cnt != '0);
  assign tok_data  = q[0];
  assign pop       = tok_valid && !tok_stall;

  assign c     = chr_data.char_code;
  assign dig   = is_digit(c);
  assign let_c = is_letter(c);
  assign sgl   = single_lookup(c);

  // Decode the accepted item against the pending run.
  always_comb begin
    cont = !chr_data.op &&
           ((run_kind == RUN_NUMBER && dig) || (run_kind == RUN_WORD && let_c));
    flush = !cont && (run_kind != RUN_NONE);

    // Token for the pending run.
    run_tok.token_type     = (run_kind == RUN_NUMBER) ? TOK_NUMBER :
                             word_type(run_text, run_length, run_overflow);
    run_tok.token_text     = run_text;
    run_tok.token_length   = run_length;
    run_tok.text_truncated = run_overflow;
    run_tok.token_index    = token_counter;
    run_tok.last_result    = 1'b0;

    idx_after_flush = (flush && token_counter != 8'hFF) ? token_counter + 8'd1
                                                        : token_counter;
    idx_inc = (idx_after_flush != 8'hFF) ? idx_after_flush + 8'd1 : idx_after_flush;

    // Token of the item itself.
    own_tok.token_text     = {56'd0, c};
    own_tok.token_length   = 4'd1;
    own_tok.text_truncated = 1'b0;
    own_tok.token_index    = idx_after_flush;
    own_tok.last_result    = 1'b1;
    own_tok.token_type     = sgl.hit ? sgl.token_type : TOK_INVALID;
    has_own = 1'b0;

    run_kind_next      = run_kind;
    run_text_next      = run_text;
    run_length_next    = run_length;
    run_overflow_next  = run_overflow;
    token_counter_next = token_counter;

    if (accept) begin
      if (flush) begin
        run_kind_next     = RUN_NONE;
        run_text_next     = '0;
        run_length_next   = '0;
        run_overflow_next = 1'b0;
      end
      token_counter_next = idx_after_flush;
      if (chr_data.op) begin
        // End of line: end marker, then restart the count.
        has_own                = 1'b1;
        own_tok.token_type     = TOK_END;
        own_tok.token_text     = '0;
        own_tok.token_length   = '0;
        token_counter_next     = '0;
      end else if (cont) begin
        // Extend the pending run.
        if (run_length < MAX_LEN) begin
          run_text_next   = run_text | (64'(c) << {run_length[2:0], 3'b000});
          run_length_next = run_length + 4'd1;
        end else begin
          run_overflow_next = 1'b1;
        end
      end else if (c == CH_SPACE) begin
        has_own = 1'b0;
      end else if (dig || let_c) begin
        // Start a new run.
        run_kind_next     = dig ? RUN_NUMBER : RUN_WORD;
        run_text_next     = {56'd0, c};
        run_length_next   = 4'd1;
        run_overflow_next = 1'b0;
      end else begin
        // Single-character or unknown character token.
        has_own            = 1'b1;
        token_counter_next = idx_inc;
      end
    end

    // Order the results of this item.
    r1 = own_tok;
    if (flush) begin
      r0             = run_tok;
      r0.last_result = !has_own;
      n_res          = has_own ? 2'd2 : 2'd1;
    end else begin
      r0    = own_tok;
      n_res = has_own ? 2'd1 : 2'd0;
    end
    if (!accept) n_res = 2'd0;
  end

  // Result queue: shift on pop, append new results behind the survivors.
  always_comb begin
    base = cnt - QUEUE_CW'(pop);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_next[i] = (pop && i < QUEUE_DEPTH - 1) ? q[(i + 1) % QUEUE_DEPTH] : q[i];
      if (n_res != 2'd0 && QUEUE_CW'(i) == base) q_next[i] = r0;
      if (n_res == 2'd2 && QUEUE_CW'(i) == base + QUEUE_CW'(1)) q_next[i] = r1;
    end
    cnt_next = base + QUEUE_CW'(n_res);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind      <= RUN_NONE;
      run_text      <= '0;
      run_length    <= '0;
      run_overflow  <= 1'b0;
      token_counter <= '0;
      cnt           <= '0;
    end else begin
      run_kind      <= run_kind_next;
      run_text      <= run_text_next;
      run_length    <= run_length_next;
      run_overflow  <= run_overflow_next;
      token_counter <= token_counter_next;
      cnt           <= cnt_next;
    end
  end

  // Queue payload.
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  // Checks.
  `ETL_ASSERT_ALWAYS(a_queue_bound, clk, rst, cnt <= QUEUE_CW'(QUEUE_DEPTH), "result queue overflow")
  `ETL_ASSERT_ALWAYS(a_run_bound, clk, rst, run_length <= MAX_LEN, "run length beyond limit")
  `ETL_ASSERT_NEXT(a_eol_clears, clk, rst, accept && chr_data.op, run_kind == RUN_NONE && token_counter == 8'd0, "end of line left state behind")
  `ETL_ASSERT_ALWAYS(a_end_empty, clk, rst, !(tok_valid && tok_data.token_type == TOK_END) || (tok_data.token_length == 4'd0 && tok_data.last_result), "malformed end marker")

endmodule
`default_nettype wire
